@@ hdl/mbrtu_pkg.sv @@
package mbrtu_pkg;

  // Modbus CRC-16: reflected polynomial, all-ones start value.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Smallest legal frame: address, function code, two CRC bytes.
  localparam int MIN_FRAME = 4;
  // Address byte plus the two CRC bytes around the PDU.
  localparam int FRAME_OVERHEAD = 3;

  // Most results one input item can produce: address, data, CRC low, CRC high.
  localparam int MAX_RES = 4;

  localparam logic FUNC_RX = 1'b0;
  localparam logic FUNC_TX = 1'b1;

  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  typedef logic [2:0] rcnt_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_v;
    logic       last;
    logic       ok;
    logic [7:0] addr;
    logic [7:0] len;
  } res_t;

  // Batch of results handed from the engine to the output queue.
  typedef struct packed {
    logic                     valid;
    rcnt_t                    n;
    res_t [MAX_RES-1:0]       ents;
  } load_t;

endpackage

@@ hdl/mbrtu_ifs.sv @@
interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;
  logic       in_last;
  logic [7:0] slave_addr;

  modport source (output valid, output func, output in_byte, output in_last,
                  output slave_addr, input ready);
  modport sink (input valid, input func, input in_byte, input in_last,
                input slave_addr, output ready);
endinterface

interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       frame_ok;
  logic [7:0] rx_addr;
  logic [7:0] pdu_length;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  output frame_ok, output rx_addr, output pdu_length, input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_last,
                input frame_ok, input rx_addr, input pdu_length, output ready);
endinterface

@@ hdl/mbrtu_crc8.sv @@
module mbrtu_crc8 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  logic [15:0] c;

  // Eight reflected shift steps, flattened into one XOR network.
  always_comb begin
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mbrtu_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

@@ hdl/mbrtu_engine.sv @@
module mbrtu_engine #(
  parameter int MAX_FRAME = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  mbrtu_in_if.sink          in_ch,
  input  logic              q_free,
  output mbrtu_pkg::load_t  load
);

  localparam int CW = $clog2(MAX_FRAME + 2);
  localparam logic [CW-1:0] CNT_SAT = CW'(MAX_FRAME + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME);
  localparam logic [CW-1:0] CNT_MIN = CW'(mbrtu_pkg::MIN_FRAME);
  localparam logic [CW-1:0] CNT_OVH = CW'(mbrtu_pkg::FRAME_OVERHEAD);

  // Input register.
  logic       vld_r;
  logic       func_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic [7:0] addr_r;

  // Frame state.
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    h0_r, h0_nxt;
  logic [7:0]    h1_r, h1_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    fb_r, fb_nxt;

  logic [15:0]   crc_a, crc_b, crc_b_in;
  logic [7:0]    crc_a_data;
  logic [CW-1:0] cnt1, cnt2;
  logic          first;
  logic          rx_ok;
  logic          proceed;
  mbrtu_pkg::rcnt_t                       n;
  mbrtu_pkg::res_t [mbrtu_pkg::MAX_RES-1:0] res;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    sat_inc = (c == CNT_SAT) ? c : c + CW'(1);
  endfunction

  assign first = (cnt_r == '0);

  // One CRC step for the held byte (receive) or the address (transmit),
  // a second one for the transmitted data byte.
  assign crc_a_data = (func_r == mbrtu_pkg::FUNC_RX) ? h0_r : addr_r;
  assign crc_b_in   = first ? crc_a : crc_r;

  mbrtu_crc8 u_crc_a (.crc_in(crc_r),    .data_in(crc_a_data), .crc_out(crc_a));
  mbrtu_crc8 u_crc_b (.crc_in(crc_b_in), .data_in(byte_r),     .crc_out(crc_b));

  always_comb begin
    crc_nxt = crc_r;
    h0_nxt  = h0_r;
    h1_nxt  = h1_r;
    cnt_nxt = cnt_r;
    fb_nxt  = fb_r;
    res     = '0;
    n       = '0;
    rx_ok   = 1'b0;
    cnt1    = first ? CW'(1) : cnt_r;
    cnt2    = sat_inc(cnt_r);
    if (func_r == mbrtu_pkg::FUNC_RX) begin
      if (first) begin
        fb_nxt = byte_r;
      end
      if (cnt_r >= CW'(2)) begin
        crc_nxt = crc_a;
      end
      h0_nxt  = h1_r;
      h1_nxt  = byte_r;
      cnt_nxt = cnt2;
      // The trailing CRC arrives low byte first: h1_r is the low byte.
      rx_ok = (cnt2 >= CNT_MIN) && (cnt2 <= CNT_MAX) && ({byte_r, h1_r} == crc_nxt);
      if (last_r) begin
        n             = mbrtu_pkg::rcnt_t'(1);
        res[0].kind   = mbrtu_pkg::KIND_RX;
        res[0].last   = 1'b1;
        res[0].ok     = rx_ok;
        res[0].addr   = rx_ok ? fb_nxt : 8'h00;
        res[0].len    = rx_ok ? 8'(cnt2 - CNT_OVH) : 8'h00;
      end
    end else begin
      cnt2    = sat_inc(cnt1);
      crc_nxt = crc_b;
      cnt_nxt = cnt2;
      if (first) begin
        fb_nxt        = addr_r;
        res[0].kind   = mbrtu_pkg::KIND_TX;
        res[0].byte_v = addr_r;
        res[1].kind   = mbrtu_pkg::KIND_TX;
        res[1].byte_v = byte_r;
        res[1].last   = ~last_r;
        res[2].byte_v = crc_b[7:0];
        res[3].byte_v = crc_b[15:8];
        res[3].last   = 1'b1;
        n = last_r ? mbrtu_pkg::rcnt_t'(4) : mbrtu_pkg::rcnt_t'(2);
      end else begin
        res[0].kind   = mbrtu_pkg::KIND_TX;
        res[0].byte_v = byte_r;
        res[0].last   = ~last_r;
        res[1].byte_v = crc_b[7:0];
        res[2].byte_v = crc_b[15:8];
        res[2].last   = 1'b1;
        n = last_r ? mbrtu_pkg::rcnt_t'(3) : mbrtu_pkg::rcnt_t'(1);
      end
    end
    // The end of a frame or PDU returns the state to its reset value.
    if (last_r) begin
      crc_nxt = mbrtu_pkg::CRC_INIT;
      h0_nxt  = '0;
      h1_nxt  = '0;
      cnt_nxt = '0;
      fb_nxt  = '0;
    end
  end

  // An item that produces no result never waits for the output queue.
  assign proceed     = vld_r && ((n == '0) || q_free);
  assign in_ch.ready = !vld_r || proceed;

  assign load.valid = proceed && (n != '0);
  assign load.n     = n;
  assign load.ents  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      crc_r <= mbrtu_pkg::CRC_INIT;
      h0_r  <= '0;
      h1_r  <= '0;
      cnt_r <= '0;
      fb_r  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        vld_r <= 1'b1;
      end else if (proceed) begin
        vld_r <= 1'b0;
      end
      if (proceed) begin
        crc_r <= crc_nxt;
        h0_r  <= h0_nxt;
        h1_r  <= h1_nxt;
        cnt_r <= cnt_nxt;
        fb_r  <= fb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      byte_r <= in_ch.in_byte;
      last_r <= in_ch.in_last;
      addr_r <= in_ch.slave_addr;
    end
  end

endmodule

@@ hdl/mbrtu_outq.sv @@
module mbrtu_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  mbrtu_pkg::load_t  load,
  output logic              q_free,
  mbrtu_out_if.source       out_ch
);

  mbrtu_pkg::res_t [mbrtu_pkg::MAX_RES-1:0] ent_r;
  mbrtu_pkg::rcnt_t rem_r;
  logic pop;

  assign out_ch.valid      = (rem_r != '0);
  assign pop               = out_ch.valid && out_ch.ready;
  assign out_ch.out_kind   = ent_r[0].kind;
  assign out_ch.out_byte   = ent_r[0].byte_v;
  assign out_ch.out_last   = ent_r[0].last;
  assign out_ch.frame_ok   = ent_r[0].ok;
  assign out_ch.rx_addr    = ent_r[0].addr;
  assign out_ch.pdu_length = ent_r[0].len;

  // A new batch may land when the queue is empty or its last entry leaves now.
  assign q_free = (rem_r == '0) || ((rem_r == mbrtu_pkg::rcnt_t'(1)) && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load.valid) begin
      rem_r <= load.n;
    end else if (pop) begin
      rem_r <= rem_r - mbrtu_pkg::rcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      ent_r <= load.ents;
    end else if (pop) begin
      ent_r <= ent_r >> $bits(mbrtu_pkg::res_t);
    end
  end

endmodule

@@ hdl/modbus_rtu_frame_check_and_build.sv @@
// Modbus RTU frame engine with one CRC-16 (polynomial 0xA001, start 0xFFFF).
// With func = 0 each transfer is one received frame byte; the byte marked last
// yields one verdict carrying frame_ok, the address and the PDU length. With
// func = 1 each transfer is one PDU byte; the slave address goes out ahead of
// the first byte and the CRC, low byte first, after the last. An item is
// registered on input and turned into its results by a byte-wide CRC
// network; the results are registered in a four-entry queue, which takes a
// batch only when it is free, and leave it at one per cycle while the result
// port is ready. A received byte makes zero or one result, a transmitted
// byte up to four. The next item is taken while the queue drains.
module modbus_rtu_frame_check_and_build #(
  parameter int MAX_FRAME = 256
) (
  input logic          clk,
  input logic          rst_n,
  mbrtu_in_if.sink     in_ch,
  mbrtu_out_if.source  out_ch
);

  mbrtu_pkg::load_t load;
  logic             q_free;

  mbrtu_engine #(.MAX_FRAME(MAX_FRAME)) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_free (q_free),
    .load   (load)
  );

  mbrtu_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .q_free (q_free),
    .out_ch (out_ch)
  );

  // A batch only lands in a queue that is free to take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |-> q_free)
    else $error("result batch loaded into a busy queue");

  // A receive verdict is always the last result of its item.
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_kind == mbrtu_pkg::KIND_RX) |-> out_ch.out_last)
    else $error("receive verdict without last mark");

  // A rejected frame reports neither address nor length.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_kind == mbrtu_pkg::KIND_RX && !out_ch.frame_ok)
      |-> (out_ch.rx_addr == 8'h00 && out_ch.pdu_length == 8'h00))
    else $error("rejected frame carries address or length");

  // An accepted frame holds at least one PDU byte.
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_kind == mbrtu_pkg::KIND_RX && out_ch.frame_ok)
      |-> (out_ch.pdu_length != 8'h00))
    else $error("accepted frame with empty PDU");

endmodule
